### sv/websocket_frame_deframer_macros.svh
// assertion macros shared by the deframer checker
// no dependencies; included by bare file name
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, disabled while reset is low
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

### sv/wsd_pkg.sv
// types and constants of the websocket frame deframer
// no dependencies; used by the top level and its checker
package wsd_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [63:0] t_len;
    typedef logic [31:0] t_mask_key;

    // 7-bit length codes that select an extended length field
    localparam logic [6:0] LEN_CODE_16 = 7'h7e;
    localparam logic [6:0] LEN_CODE_64 = 7'h7f;

    // extended length sizes in bytes
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;

    // last byte index of the mask key
    localparam logic [2:0] MASK_LAST_IDX = 3'd3;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_EMPTY   = 1'b1;

endpackage

### sv/websocket_frame_deframer.sv
// websocket frame deframer, receive side, one stream byte per transaction
// depends on wsd_pkg
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | sink      | i_in_valid / o_in_ready   | i_data_byte
//  out     | source    | o_out_valid / i_out_ready | o_kind o_data_out o_opcode o_fin
//          |           |                           | o_reserved_bits o_was_masked
//          |           |                           | o_payload_length o_last
//
//  one byte per cycle sustained while the output is not stalled; a byte's result
//  goes through the input register, then is parsed into the result register
//  header bytes give no result, except the one that closes a zero-length header
//  reset (i_rst_n low at a clock edge) clears the parser state and both valids
//  an output stall holds the result; the input register still takes one more byte
//  and then o_in_ready drops until the result is taken
module websocket_frame_deframer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wsd_pkg::t_byte i_data_byte,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_kind,
    output wsd_pkg::t_byte o_data_out,
    output logic [3:0]     o_opcode,
    output logic           o_fin,
    output logic [2:0]     o_reserved_bits,
    output logic           o_was_masked,
    output wsd_pkg::t_len  o_payload_length,
    output logic           o_last
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD
    } t_phase;

    // input register
    logic       r_in_valid;
    t_byte      r_in_byte;

    // parser state
    t_phase     r_phase,        n_phase;
    logic [2:0] r_field_idx,    n_field_idx;
    logic       r_wide_len,     n_wide_len;
    t_byte      r_first_hdr,    n_first_hdr;
    logic       r_mask_present, n_mask_present;
    t_len       r_frame_len,    n_frame_len;
    t_len       r_bytes_rem,    n_bytes_rem;
    t_mask_key  r_mask_key,     n_mask_key;
    logic [1:0] r_mask_idx,     n_mask_idx;

    // result register
    logic       r_out_valid;
    logic       r_kind,         n_kind;
    t_byte      r_data_out,     n_data_out;
    t_byte      r_first_hdr_o;
    logic       r_masked_o;
    t_len       r_len_o;
    logic       r_last,         n_last;

    logic       emit;
    logic       length_done;
    logic       begin_payload;
    logic       advance;
    logic [3:0] ext_need;
    logic [3:0] ext_count;
    logic [1:0] key_sel;
    t_byte      key_byte;
    logic       pay_last;

    // the parse stage moves whenever the result register is free or drains
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    // mask key byte for this payload index, first key byte in the top bits
    assign key_sel  = 2'd3 - r_mask_idx;
    assign key_byte = r_mask_present ? r_mask_key[{key_sel, 3'b000} +: 8] : '0;
    assign pay_last = (r_bytes_rem <= 64'd1);

    assign ext_need  = r_wide_len ? EXT_BYTES_64 : EXT_BYTES_16;
    assign ext_count = {1'b0, r_field_idx} + 4'd1;

    always_comb begin
        n_phase        = r_phase;
        n_field_idx    = r_field_idx;
        n_wide_len     = r_wide_len;
        n_first_hdr    = r_first_hdr;
        n_mask_present = r_mask_present;
        n_frame_len    = r_frame_len;
        n_bytes_rem    = r_bytes_rem;
        n_mask_key     = r_mask_key;
        n_mask_idx     = r_mask_idx;
        n_kind         = KIND_PAYLOAD;
        n_data_out     = '0;
        n_last         = 1'b0;
        emit           = 1'b0;
        length_done    = 1'b0;
        begin_payload  = 1'b0;

        case (r_phase)
            PH_HDR2: begin
                n_mask_present = r_in_byte[7];
                n_mask_key     = '0;
                n_field_idx    = '0;
                if (r_in_byte[6:0] == LEN_CODE_16 || r_in_byte[6:0] == LEN_CODE_64) begin
                    n_wide_len  = (r_in_byte[6:0] == LEN_CODE_64);
                    n_frame_len = '0;
                    n_phase     = PH_EXTLEN;
                end else begin
                    n_wide_len  = 1'b0;
                    n_frame_len = {57'd0, r_in_byte[6:0]};
                    length_done = 1'b1;
                end
            end
            PH_EXTLEN: begin
                // big-endian, shift in one byte per transaction
                n_frame_len = {r_frame_len[55:0], r_in_byte};
                if (ext_count >= ext_need) begin
                    length_done = 1'b1;
                end else begin
                    n_field_idx = ext_count[2:0];
                end
            end
            PH_MASK: begin
                n_mask_key = {r_mask_key[23:0], r_in_byte};
                if (r_field_idx >= MASK_LAST_IDX) begin
                    n_field_idx   = '0;
                    begin_payload = 1'b1;
                end else begin
                    n_field_idx = ext_count[2:0];
                end
            end
            PH_PAYLOAD: begin
                emit       = 1'b1;
                n_kind     = KIND_PAYLOAD;
                n_data_out = r_in_byte ^ key_byte;
                n_last     = pay_last;
                n_mask_idx = r_mask_idx + 2'd1;
                if (pay_last) begin
                    n_bytes_rem = '0;
                    n_phase     = PH_HDR1;
                end else begin
                    n_bytes_rem = r_bytes_rem - 64'd1;
                end
            end
            default: begin
                // first header byte, also taken for unused phase codes
                n_first_hdr = r_in_byte;
                n_field_idx = '0;
                n_phase     = PH_HDR2;
            end
        endcase

        // length field complete: go for the mask key or straight to payload
        if (length_done) begin
            n_field_idx = '0;
            if (n_mask_present) begin
                n_phase = PH_MASK;
            end else begin
                begin_payload = 1'b1;
            end
        end

        // header complete: a zero-length frame reports one empty result
        if (begin_payload) begin
            n_mask_idx = '0;
            if (n_frame_len == '0) begin
                n_bytes_rem = '0;
                n_phase     = PH_HDR1;
                emit        = 1'b1;
                n_kind      = KIND_EMPTY;
                n_data_out  = '0;
                n_last      = 1'b1;
            end else begin
                n_bytes_rem = n_frame_len;
                n_phase     = PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase        <= PH_HDR1;
            r_field_idx    <= '0;
            r_wide_len     <= 1'b0;
            r_first_hdr    <= '0;
            r_mask_present <= 1'b0;
            r_frame_len    <= '0;
            r_bytes_rem    <= '0;
            r_mask_key     <= '0;
            r_mask_idx     <= '0;
        end else begin
            // input register
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            // parse stage and result register
            if (advance) begin
                r_out_valid <= r_in_valid && emit;
                if (r_in_valid) begin
                    r_phase        <= n_phase;
                    r_field_idx    <= n_field_idx;
                    r_wide_len     <= n_wide_len;
                    r_first_hdr    <= n_first_hdr;
                    r_mask_present <= n_mask_present;
                    r_frame_len    <= n_frame_len;
                    r_bytes_rem    <= n_bytes_rem;
                    r_mask_key     <= n_mask_key;
                    r_mask_idx     <= n_mask_idx;
                end
            end
        end
        // payload registers, no reset
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (advance && r_in_valid && emit) begin
            r_kind        <= n_kind;
            r_data_out    <= n_data_out;
            r_first_hdr_o <= n_first_hdr;
            r_masked_o    <= n_mask_present;
            r_len_o       <= n_frame_len;
            r_last        <= n_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_data_out       = r_data_out;
    assign o_opcode         = r_first_hdr_o[3:0];
    assign o_fin            = r_first_hdr_o[7];
    assign o_reserved_bits  = r_first_hdr_o[6:4];
    assign o_was_masked     = r_masked_o;
    assign o_payload_length = r_len_o;
    assign o_last           = r_last;

endmodule

### sv/wsd_checker.sv
// port-level checks of the websocket frame deframer, bound to the top level
// depends on wsd_pkg and websocket_frame_deframer_macros.svh
`include "websocket_frame_deframer_macros.svh"

module wsd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input wsd_pkg::t_byte i_data_byte,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input logic           o_kind,
    input wsd_pkg::t_byte o_data_out,
    input logic [3:0]     o_opcode,
    input logic           o_fin,
    input logic [2:0]     o_reserved_bits,
    input logic           o_was_masked,
    input wsd_pkg::t_len  o_payload_length,
    input logic           o_last
);
    import wsd_pkg::*;

    logic        stalled;
    logic        in_waiting;
    logic        empty_ok;
    logic [82:0] out_bus;

    assign stalled    = o_out_valid && !i_out_ready;
    assign in_waiting = i_in_valid && !o_in_ready;
    assign empty_ok   = (o_data_out == '0) && o_last && (o_payload_length == '0);
    assign out_bus    = {o_kind, o_data_out, o_opcode, o_fin, o_reserved_bits,
                         o_was_masked, o_payload_length, o_last};

    // a stalled result holds
    `WSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stalled, o_out_valid && $stable(out_bus))
    // a waiting input byte holds
    `WSD_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_waiting, i_in_valid && $stable(i_data_byte))
    // an empty-frame result is always the last one with a zero length
    `WSD_ASSERT_NOW(a_empty_frame, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_EMPTY), empty_ok)
    // a payload byte only comes from a frame with a nonzero length
    `WSD_ASSERT_NOW(a_payload_len, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_PAYLOAD), o_payload_length != '0)
    // with no result waiting the block always takes a byte
    `WSD_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !o_out_valid, o_in_ready)

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_data_byte      (i_data_byte),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_kind           (o_kind),
    .o_data_out       (o_data_out),
    .o_opcode         (o_opcode),
    .o_fin            (o_fin),
    .o_reserved_bits  (o_reserved_bits),
    .o_was_masked     (o_was_masked),
    .o_payload_length (o_payload_length),
    .o_last           (o_last)
);

### tb/sv/tb_websocket_frame_deframer.sv
// self-checking testbench for the websocket frame deframer, one file
// depends on wsd_pkg and websocket_frame_deframer; keeps its own frame parser as predictor
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;

    import wsd_pkg::*;

    // parser phases of the predictor
    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD
    } t_parse_phase;

    // one result transaction as seen on the output port
    typedef struct packed {
        logic       kind;
        t_byte      data;
        logic [3:0] opcode;
        logic       fin;
        logic [2:0] rsv;
        logic       masked;
        t_len       plen;
        logic       last;
    } t_frame_result;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_byte      i_data_byte = '0;
    logic       i_out_ready = 1'b1;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_kind;
    t_byte      o_data_out;
    logic [3:0] o_opcode;
    logic       o_fin;
    logic [2:0] o_reserved_bits;
    logic       o_was_masked;
    t_len       o_payload_length;
    logic       o_last;

    websocket_frame_deframer u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_data_out       (o_data_out),
        .o_opcode         (o_opcode),
        .o_fin            (o_fin),
        .o_reserved_bits  (o_reserved_bits),
        .o_was_masked     (o_was_masked),
        .o_payload_length (o_payload_length),
        .o_last           (o_last)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // results predicted but not yet seen on the output, oldest first
    t_frame_result expected_payload_q[$];

    // predictor state: mirrors what the deframer tracks per frame
    t_parse_phase ps_phase     = PH_HDR1;
    logic [2:0]   ps_field_idx = '0;
    logic         ps_wide      = 1'b0;
    t_byte        ps_hdr1      = '0;
    logic         ps_masked    = 1'b0;
    t_len         ps_len       = '0;
    t_len         ps_left      = '0;
    t_mask_key    ps_key       = '0;
    logic [1:0]   ps_key_idx   = '0;

    // random idling switches, flipped now and then to get stretches without gaps
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;

    int unsigned sent_bytes      = 0;
    int unsigned frames_sent     = 0;
    int unsigned checked_results = 0;
    int unsigned empty_headers   = 0;
    int unsigned mismatches      = 0;
    int unsigned stall_left      = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic t_frame_result make_result(logic kind, t_byte data, logic last);
        t_frame_result r;
        r.kind   = kind;
        r.data   = data;
        r.opcode = ps_hdr1[3:0];
        r.fin    = ps_hdr1[7];
        r.rsv    = ps_hdr1[6:4];
        r.masked = ps_masked;
        r.plen   = ps_len;
        r.last   = last;
        return r;
    endfunction

    // header complete (length and key if any): either payload follows or
    // a zero-length frame closes right here with an empty result
    function automatic void start_payload();
        ps_key_idx = '0;
        if (ps_len == '0) begin
            ps_left  = '0;
            ps_phase = PH_HDR1;
            expected_payload_q.push_back(make_result(KIND_EMPTY, 8'h00, 1'b1));
            empty_headers++;
        end else begin
            ps_left  = ps_len;
            ps_phase = PH_PAYLOAD;
        end
    endfunction

    // length known: a mask key comes next if the frame is masked
    function automatic void length_done();
        ps_field_idx = '0;
        if (ps_masked)
            ps_phase = PH_MASK;
        else
            start_payload();
    endfunction

    function automatic void deframe_byte(t_byte b);
        logic [6:0] code;
        t_byte      key_byte;
        logic       is_last;
        case (ps_phase)
            PH_HDR2: begin
                ps_masked    = b[7];
                code         = b[6:0];
                ps_key       = '0;
                ps_field_idx = '0;
                if (code == LEN_CODE_16 || code == LEN_CODE_64) begin
                    ps_wide  = (code == LEN_CODE_64);
                    ps_len   = '0;
                    ps_phase = PH_EXTLEN;
                end else begin
                    ps_wide = 1'b0;
                    ps_len  = t_len'(code);
                    length_done();
                end
            end
            PH_EXTLEN: begin
                // big-endian, all 64 bits kept as given
                ps_len = {ps_len[55:0], b};
                if (4'(ps_field_idx) + 4'd1 >= (ps_wide ? EXT_BYTES_64 : EXT_BYTES_16))
                    length_done();
                else
                    ps_field_idx = ps_field_idx + 3'd1;
            end
            PH_MASK: begin
                ps_key = {ps_key[23:0], b};
                if (ps_field_idx >= MASK_LAST_IDX) begin
                    ps_field_idx = '0;
                    start_payload();
                end else begin
                    ps_field_idx = ps_field_idx + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                // key byte 0 sits in bits 31..24
                key_byte = ps_masked ? ps_key[8 * (3 - ps_key_idx) +: 8] : 8'h00;
                is_last  = (ps_left <= 64'd1);
                expected_payload_q.push_back(make_result(KIND_PAYLOAD, b ^ key_byte, is_last));
                ps_key_idx = ps_key_idx + 2'd1;
                if (is_last) begin
                    ps_left  = '0;
                    ps_phase = PH_HDR1;
                end else begin
                    ps_left = ps_left - 64'd1;
                end
            end
            default: begin
                ps_hdr1      = b;
                ps_field_idx = '0;
                ps_phase     = PH_HDR2;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // output side: random stalls and result checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result();
        t_frame_result want;
        if (expected_payload_q.size() == 0) begin
            $display("%0t ns: result with nothing expected, expected none actual data %0h last %0b",
                     $time, o_data_out, o_last);
            mismatches++;
            return;
        end
        want = expected_payload_q.pop_front();
        check_field("kind",           64'(want.kind),   64'(o_kind));
        check_field("data_out",       64'(want.data),   64'(o_data_out));
        check_field("opcode",         64'(want.opcode), 64'(o_opcode));
        check_field("fin",            64'(want.fin),    64'(o_fin));
        check_field("reserved_bits",  64'(want.rsv),    64'(o_reserved_bits));
        check_field("was_masked",     64'(want.masked), 64'(o_was_masked));
        check_field("payload_length", want.plen,        o_payload_length);
        check_field("last",           64'(want.last),   64'(o_last));
        checked_results++;
    endtask

    // after each taken result the receiver draws a random stall while recv_idle is set
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_result();
            stall_left = recv_idle ? $urandom_range(9, 0) : 0;
            if (stall_left != 0)
                i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            if (stall_left == 0)
                i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // one stream byte per transaction; valid stays high between back-to-back
    // bytes so it is never lowered and raised in the same step
    task automatic send_byte(input t_byte b);
        int unsigned gap;
        gap = send_idle ? $urandom_range(9, 0) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        deframe_byte(b);
        sent_bytes++;
    endtask

    // header, extended length and key as the code asks, then n_payload random bytes
    task automatic send_frame(input t_byte hdr1, input logic masked, input logic [6:0] code,
                              input t_len len, input t_mask_key key, input int unsigned n_payload);
        send_byte(hdr1);
        send_byte({masked, code});
        if (code == LEN_CODE_16) begin
            for (int i = 1; i >= 0; i--)
                send_byte(len[8 * i +: 8]);
        end else if (code == LEN_CODE_64) begin
            for (int i = 7; i >= 0; i--)
                send_byte(len[8 * i +: 8]);
        end
        if (masked) begin
            for (int i = 3; i >= 0; i--)
                send_byte(key[8 * i +: 8]);
        end
        repeat (n_payload) send_byte(t_byte'($urandom_range(255, 0)));
        frames_sent++;
    endtask

    // hold off the sender until the output has caught up
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_payload_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // zero-length frames: unmasked closes on the second byte, masked on the
    // last key byte
    task automatic test_empty_frames();
        send_frame(8'h89, 1'b0, 7'd0, '0, '0, 0);
        send_frame(8'h0a, 1'b1, 7'd0, '0, 32'hdead_beef, 0);
    endtask

    // all reserved bits set, unknown opcode, every key byte position used,
    // payload extremes
    task automatic test_masked_payload();
        send_frame(8'hf3, 1'b1, 7'd5, '0, 32'ha55a_ff00, 0);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h3c);
        send_byte(8'hc3);
        send_byte(8'h81);
    endtask

    // 16-bit extended length holding a value that would fit the short code
    task automatic test_short_ext_length();
        send_frame(8'h02, 1'b0, LEN_CODE_16, 64'd1, '0, 1);
    endtask

    // well-formed frames with random header, length coding, key and payload
    task automatic test_random_frames(input int unsigned n_bytes);
        int unsigned start_bytes;
        int unsigned sel;
        logic        masked;
        logic [6:0]  code;
        t_len        len;
        start_bytes = sent_bytes;
        while (sent_bytes - start_bytes < n_bytes) begin
            if ($urandom_range(7, 0) == 0) send_idle = ~send_idle;
            if ($urandom_range(7, 0) == 0) recv_idle = ~recv_idle;
            masked = 1'($urandom_range(1, 0));
            sel    = $urandom_range(9, 0);
            if (sel < 6) begin
                // mostly short frames, now and then up to the largest short code
                len  = t_len'(($urandom_range(3, 0) == 0) ? $urandom_range(125, 0)
                                                           : $urandom_range(8, 0));
                code = len[6:0];
            end else if (sel < 8) begin
                code = LEN_CODE_16;
                len  = t_len'(($urandom_range(15, 0) == 0) ? $urandom_range(300, 0)
                                                            : $urandom_range(12, 0));
            end else begin
                code = LEN_CODE_64;
                len  = t_len'($urandom_range(12, 0));
            end
            send_frame(t_byte'($urandom_range(255, 0)), masked, code, len,
                       t_mask_key'($urandom()), 32'(len));
            if ($urandom_range(39, 0) == 0)
                wait_drained();
        end
    endtask

    // all-ones 64-bit length: only a few payload bytes are sent, the frame
    // never ends, so this runs last
    task automatic test_huge_length();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_frame(8'h70, 1'b1, LEN_CODE_64, '1, t_mask_key'($urandom()), 12);
    endtask

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_frames();
        test_masked_payload();
        test_short_ext_length();
        wait_drained();
        test_random_frames(700);
        wait_drained();
        test_huge_length();

        i_in_valid <= 1'b0;
        while (expected_payload_q.size() != 0) @(posedge i_clk);
        // two-stage pipeline; keep clocking a while to catch a stray result
        repeat (8) @(posedge i_clk);

        $display("covered %0d bytes in %0d frames, %0d results checked (%0d empty frames)",
                 sent_bytes, frames_sent, checked_results, empty_headers);
        $display("short, 16-bit and 64-bit lengths, masked and unmasked, random stalls on both sides");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // run guard, far above the slowest correct run
    initial begin : watchdog
        #5ms;
        $display("timeout with %0d results still outstanding", expected_payload_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
